>>> hw/rtl/vwma_pkg.sv
// Shared types and constants for the variable-window moving-average filter.
package vwma_pkg;

    localparam int AVG_BITS       = 12;
    localparam int IN_SAMPLE_BITS = 12;
    localparam int WIN_BITS       = 11;
    localparam int STEP_BITS      = 5;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_WINDOW  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_STEP = 1'd1;

    localparam logic [WIN_BITS-1:0]  RESET_MAX_WINDOW  = 11'd600;
    localparam logic [STEP_BITS-1:0] RESET_WINDOW_STEP = 5'd2;
    localparam logic [WIN_BITS-1:0]  RESET_WINDOW      = 11'd2;
    localparam logic [WIN_BITS-1:0]  MIN_WINDOW        = 11'd2;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_PRESS  = 1'b1;

    typedef struct packed {
        logic                      func;
        logic [IN_SAMPLE_BITS-1:0] sample;
    } vwma_in_t;

    typedef struct packed {
        logic [AVG_BITS-1:0] average;
        logic [WIN_BITS-1:0] window_size;
    } vwma_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SMP_UPD,
        ST_DIV,
        ST_OUT,
        ST_PRS_RD,
        ST_PRS_ACC
    } vwma_state_t;

endpackage

>>> hw/rtl/vwma_serial_div.sv
// Bit-serial restoring divider that shifts out one quotient bit per cycle.
module vwma_serial_div #(
    parameter int QUOT_BITS = 12,
    parameter int DIVR_BITS = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [QUOT_BITS+DIVR_BITS-1:0] dividend,
    input  logic [DIVR_BITS-1:0]           divisor,
    output logic                           done,
    output logic [QUOT_BITS-1:0]           quotient
);

    localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

    logic [DIVR_BITS-1:0] rem_reg, rem_next;
    logic [DIVR_BITS-1:0] divr_reg, divr_next;
    logic [QUOT_BITS-1:0] sh_reg, sh_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVR_BITS:0]   trial;
    logic [DIVR_BITS:0]   diff;
    logic                 fits;

    // The high part of the dividend is below the divisor, so only the
    // quotient's own bits need a step each.
    always_comb
    begin
        trial     = {rem_reg, sh_reg[QUOT_BITS-1]};
        diff      = trial - {1'b0, divr_reg};
        fits      = (trial >= {1'b0, divr_reg});
        rem_next  = rem_reg;
        divr_next = divr_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[QUOT_BITS+DIVR_BITS-1:QUOT_BITS];
            sh_next   = dividend[QUOT_BITS-1:0];
            divr_next = divisor;
            cnt_next  = CNT_BITS'(QUOT_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVR_BITS-1:0] : trial[DIVR_BITS-1:0];
            sh_next  = {sh_reg[QUOT_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        divr_reg <= divr_next;
        sh_reg   <= sh_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

>>> hw/rtl/variable_window_moving_average.sv
// Top level of the variable-window moving-average filter.
// A sample word is written to the buffer and folded into the running sum, then divided by the
// serial divider; the next word is taken only after its average has been registered for output.
// A button press steps the window and adds or removes each stored entry that enters or leaves it.
// Reset is asynchronous and active low; the buffer reads as zero through a fill count,
// so no clearing pass is needed and the block is ready right after reset.
module variable_window_moving_average #(
    parameter int BUFFER_DEPTH = 1024,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  vwma_pkg::vwma_in_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output vwma_pkg::vwma_out_t                  out_data,
    input  logic                                 cfg_write,
    input  logic [vwma_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [vwma_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import vwma_pkg::*;

    // Index width of the buffer, total width of the running sum, and a common
    // width for comparing indexes, counts and window sizes.
    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam int TW = SAMPLE_BITS + WIN_BITS;
    localparam int CW = (IW + 1 > WIN_BITS + 1) ? IW + 1 : WIN_BITS + 1;

    vwma_state_t state_reg, state_next;

    logic [IW-1:0]          wr_idx_reg, wr_idx_next;
    logic [IW:0]            fill_reg, fill_next;
    logic [WIN_BITS-1:0]    window_reg, window_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [WIN_BITS-1:0]    max_window_reg, max_window_next;
    logic [STEP_BITS-1:0]   window_step_reg, window_step_next;
    logic                   out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [CW-1:0]          hi_reg, hi_next;
    logic                   sub_reg, sub_next;
    vwma_out_t              out_data_reg, out_data_next;

    // Sample buffer: one write port, one read port with registered data.
    logic [SAMPLE_BITS-1:0] sample_mem [BUFFER_DEPTH];
    logic [SAMPLE_BITS-1:0] mem_rd_reg;
    logic [IW-1:0]          mem_rd_addr;
    logic                   mem_we;

    // Window arithmetic.
    logic [CW-1:0] win_ext, idx_ext, fill_ext, depth_ext, mw_ext;
    logic [CW-1:0] cap, step_sum, new_win, sweep_lo, sweep_hi, sweep_hi_eff;
    logic [CW-1:0] idx_inc, ptr_inc;
    logic [TW-1:0] old_entry, new_entry, total_upd;

    // Divider hookup.
    logic                   div_start;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] div_quot;

    assign win_ext   = CW'(window_reg);
    assign idx_ext   = CW'(wr_idx_reg);
    assign fill_ext  = CW'(fill_reg);
    assign depth_ext = CW'(BUFFER_DEPTH);
    assign mw_ext    = CW'(max_window_reg);
    assign idx_inc   = idx_ext + CW'(1);
    assign ptr_inc   = ptr_reg + CW'(1);

    // The cap is the configured maximum limited to the buffer and never
    // below two. A press moves the window toward step_sum but not past the cap,
    // so a cap lowered by configuration makes the window shrink.
    always_comb
    begin
        cap = (mw_ext > depth_ext) ? depth_ext : mw_ext;
        if (cap < CW'(MIN_WINDOW))
        begin
            cap = CW'(MIN_WINDOW);
        end
        step_sum = win_ext + CW'(window_step_reg);
        new_win  = (step_sum > cap) ? cap : step_sum;
        if (new_win > win_ext)
        begin
            sweep_lo = win_ext;
            sweep_hi = new_win;
        end
        else
        begin
            sweep_lo = new_win;
            sweep_hi = win_ext;
        end
        // Entries at or above the fill count were never written and hold zero,
        // so the sweep stops there.
        sweep_hi_eff = (sweep_hi > fill_ext) ? fill_ext : sweep_hi;
    end

    // Running sum update for a sample: the new word replaces the old one in
    // the sum only when its slot lies inside the current window.
    always_comb
    begin
        old_entry = (idx_ext < fill_ext) ? TW'(mem_rd_reg) : '0;
        new_entry = TW'(smp_reg);
        total_upd = (idx_ext < win_ext) ? (total_reg - old_entry + new_entry) : total_reg;
    end

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next       = state_reg;
        wr_idx_next      = wr_idx_reg;
        fill_next        = fill_reg;
        window_next      = window_reg;
        total_next       = total_reg;
        max_window_next  = max_window_reg;
        window_step_next = window_step_reg;
        out_valid_next   = out_valid_reg;
        smp_next         = smp_reg;
        ptr_next         = ptr_reg;
        hi_next          = hi_reg;
        sub_next         = sub_reg;
        out_data_next    = out_data_reg;
        mem_we           = 1'b0;
        mem_rd_addr      = wr_idx_reg;
        div_start        = 1'b0;
        in_ready         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAX_WINDOW:  max_window_next  = cfg_data[WIN_BITS-1:0];
                REG_WINDOW_STEP: window_step_next = cfg_data[STEP_BITS-1:0];
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // The buffer read at the write index runs ahead of the update.
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.func == FUNC_SAMPLE)
                    begin
                        smp_next   = SAMPLE_BITS'(in_data.sample);
                        state_next = ST_SMP_UPD;
                    end
                    else
                    begin
                        window_next = new_win[WIN_BITS-1:0];
                        ptr_next    = sweep_lo;
                        hi_next     = sweep_hi_eff;
                        sub_next    = (new_win < win_ext);
                        if (sweep_lo < sweep_hi_eff)
                        begin
                            state_next = ST_PRS_RD;
                        end
                    end
                end
            end
            ST_SMP_UPD:
            begin
                mem_we     = 1'b1;
                total_next = total_upd;
                div_start  = 1'b1;
                if (idx_ext == fill_ext)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                if (idx_inc >= win_ext || idx_inc >= depth_ext)
                begin
                    wr_idx_next = '0;
                end
                else
                begin
                    wr_idx_next = idx_inc[IW-1:0];
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // The result waits here only while the previous word is unclaimed.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.average     = AVG_BITS'(div_quot);
                    out_data_next.window_size = window_reg;
                    state_next                = ST_IDLE;
                end
            end
            ST_PRS_RD:
            begin
                mem_rd_addr = ptr_reg[IW-1:0];
                state_next  = ST_PRS_ACC;
            end
            ST_PRS_ACC:
            begin
                // Entries that enter the window add to the sum, entries that
                // leave it are taken away.
                if (sub_reg)
                begin
                    total_next = total_reg - TW'(mem_rd_reg);
                end
                else
                begin
                    total_next = total_reg + TW'(mem_rd_reg);
                end
                ptr_next   = ptr_inc;
                state_next = (ptr_inc >= hi_reg) ? ST_IDLE : ST_PRS_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wr_idx_reg      <= '0;
            fill_reg        <= '0;
            window_reg      <= RESET_WINDOW;
            total_reg       <= '0;
            max_window_reg  <= RESET_MAX_WINDOW;
            window_step_reg <= RESET_WINDOW_STEP;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wr_idx_reg      <= wr_idx_next;
            fill_reg        <= fill_next;
            window_reg      <= window_next;
            total_reg       <= total_next;
            max_window_reg  <= max_window_next;
            window_step_reg <= window_step_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg      <= smp_next;
        ptr_reg      <= ptr_next;
        hi_reg       <= hi_next;
        sub_reg      <= sub_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[wr_idx_reg] <= smp_reg;
        end
        mem_rd_reg <= sample_mem[mem_rd_addr];
    end

    // The window sum is divided one quotient bit per cycle.
    vwma_serial_div #(
        .QUOT_BITS (SAMPLE_BITS),
        .DIVR_BITS (WIN_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_upd),
        .divisor  (window_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The write index never runs past the written part of the buffer.
    a_idx_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(wr_idx_reg) <= CW'(fill_reg))
        else $error("write index beyond fill count");

    // The window stays between two and the buffer depth.
    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        (window_reg >= MIN_WINDOW) && (CW'(window_reg) <= CW'(BUFFER_DEPTH)))
        else $error("window out of range");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // A new result appears only after the result state.
    a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result word raised outside the result state");

endmodule
